>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int FIELD_WIDTH_DEF = 32;
    localparam int MAG_W           = 64;
    localparam int MODE_W          = 4;
    localparam int IN_DATA_W       = 128;
    localparam int RES_W           = 66;
    localparam int OUT_DATA_W      = 72;

    localparam logic [MODE_W-1:0] MODE_ADD = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DIV = 4'd3;
    localparam logic [MODE_W-1:0] MODE_REM = 4'd4;
    localparam logic [MODE_W-1:0] MODE_LT  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_GT  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_EQ  = 4'd7;
    localparam logic [MODE_W-1:0] MODE_LE  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_GE  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_NE  = 4'd10;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        OP_NOP, OP_LDI, OP_GCD, OP_DIVQ, OP_DIVU, OP_DIVR,
        OP_MUL, OP_ADD, OP_SUB, OP_SGN, OP_OUT, OP_END
    } t_op;

    typedef enum logic [2:0] {
        R_AN, R_AD, R_BN, R_BD, R_RN, R_RD, R_T, R_G
    } t_reg;

    typedef enum logic [1:0] {
        K_ST0, K_ST1, K_CMP, K_ARITH
    } t_kind;

    typedef struct packed {
        logic  load_in;
        t_op   op;
        t_reg  dst;
        t_reg  s1;
        t_reg  s2;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic              busy;
        logic [MODE_W-1:0] mode;
        logic              bad_mode;
        logic              den_zero;
        logic              bn_zero;
    } t_sts;

endpackage

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, sub, mul, div, rem and compare of two signed fractions with gcd
// reduction of operands and result.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one beat carries the operand fractions in tdata and the
//   mode in tuser. Output stream: one beat per input beat with the reduced
//   result, compare flag and status.
//   The unit holds one operation at a time. An operation runs as a short
//   microprogram on a shared datapath: each reduction costs one binary gcd
//   (one step per cycle) and two restoring divisions, besides loads,
//   multiplies and adds. Arithmetic modes run three reductions, compare
//   modes two; a bad mode or a zero operand denominator skips the
//   microprogram.
//   The result sits in an output register, so the next input beat is taken
//   while the receiver stalls; a finished result waits until the previous one
//   is taken.
//   Reset (synchronous, active low) empties the output and returns to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [rau_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // mode
    input  logic [rau_pkg::MODE_W-1:0]     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // res_num, res_den, compare_true, status, zero padding
    output logic [rau_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import rau_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [RES_W-1:0] result;

    rau_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rau_datapath #(
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_in_data (i_s_tdata),
        .i_in_mode (i_s_tuser),
        .o_result  (result)
    );

    assign o_m_tdata = {{(OUT_DATA_W-RES_W){1'b0}}, result};

endmodule

>>> rtl/rau_datapath.sv
// ----------------------------------------------------------------------------
// rau_datapath
// Register file of sign/magnitude values, multiplier, adder, binary gcd unit,
// restoring divider and result formatting.
// ----------------------------------------------------------------------------
module rau_datapath #(
    parameter int FIELD_WIDTH = rau_pkg::FIELD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_cmd                 i_cmd,
    output rau_pkg::t_sts                 o_sts,
    input  logic [rau_pkg::IN_DATA_W-1:0] i_in_data,
    input  logic [rau_pkg::MODE_W-1:0]    i_in_mode,
    output logic [rau_pkg::RES_W-1:0]     o_result
);
    import rau_pkg::*;

    localparam logic [MAG_W-1:0] LIM  = {1'b0, {(MAG_W-1){1'b1}}} >> (MAG_W - FIELD_WIDTH);
    localparam logic [MAG_W-1:0] LIM1 = LIM + 64'd1;

    logic [MODE_W-1:0] r_mode;
    logic [31:0]       r_f [4];

    logic             r_rf_neg [8];
    logic [MAG_W-1:0] r_rf_mag [8];

    logic             r_opa_neg, r_opb_neg;
    logic [MAG_W-1:0] r_opa_mag, r_opb_mag;
    logic             r_pend;
    t_op              r_op;
    t_reg             r_dst;
    t_kind            r_kind;

    logic             r_grun, n_grun;
    logic [MAG_W-1:0] r_gx, n_gx, r_gy, n_gy;
    logic [5:0]       r_gk, n_gk;

    logic             r_drun, n_drun;
    logic [MAG_W-1:0] r_dq, n_dq, r_dd, n_dd;
    logic [MAG_W:0]   r_dr, n_dr;
    logic [5:0]       r_dcnt, n_dcnt;
    logic             r_drem, n_drem, r_dneg, n_dneg;

    logic [RES_W-1:0] r_out, n_out;
    logic             out_en;

    logic             wr_en, wr_neg;
    t_reg             wr_addr;
    logic [MAG_W-1:0] wr_mag;

    logic [MAG_W-1:0] prod, gval, dres, num;
    logic [MAG_W:0]   dtrial;
    logic [32:0]      ld_mag;
    logic [31:0]      ld_field;
    logic             bneg, qbit, lt, eq, ovf, cmp_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_grun <= 1'b0;
            r_drun <= 1'b0;
        end else begin
            r_pend <= (i_cmd.op != OP_NOP);
            r_grun <= n_grun;
            r_drun <= n_drun;
        end
        if (i_cmd.load_in) begin
            r_mode <= i_in_mode;
            r_f[0] <= i_in_data[31:0];
            r_f[1] <= i_in_data[63:32];
            r_f[2] <= i_in_data[95:64];
            r_f[3] <= i_in_data[127:96];
        end
        // registered operand read, two ports
        if (i_cmd.op != OP_NOP) begin
            r_op      <= i_cmd.op;
            r_dst     <= i_cmd.dst;
            r_kind    <= i_cmd.kind;
            r_opa_neg <= r_rf_neg[i_cmd.s1];
            r_opa_mag <= r_rf_mag[i_cmd.s1];
            r_opb_neg <= r_rf_neg[i_cmd.s2];
            r_opb_mag <= r_rf_mag[i_cmd.s2];
        end
        if (wr_en) begin
            r_rf_neg[wr_addr] <= wr_neg;
            r_rf_mag[wr_addr] <= wr_mag;
        end
        r_gx   <= n_gx;
        r_gy   <= n_gy;
        r_gk   <= n_gk;
        r_dq   <= n_dq;
        r_dd   <= n_dd;
        r_dr   <= n_dr;
        r_dcnt <= n_dcnt;
        r_drem <= n_drem;
        r_dneg <= n_dneg;
        if (out_en) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_dst;
        wr_neg   = 1'b0;
        wr_mag   = '0;
        out_en   = 1'b0;
        n_out    = r_out;
        n_grun   = r_grun;
        n_gx     = r_gx;
        n_gy     = r_gy;
        n_gk     = r_gk;
        n_drun   = r_drun;
        n_dq     = r_dq;
        n_dd     = r_dd;
        n_dr     = r_dr;
        n_dcnt   = r_dcnt;
        n_drem   = r_drem;
        n_dneg   = r_dneg;
        gval     = '0;
        dres     = '0;
        dtrial   = '0;
        qbit     = 1'b0;
        prod     = 64'(r_opa_mag[31:0] * r_opb_mag[31:0]);
        bneg     = r_opb_neg ^ (r_op == OP_SUB);
        ld_field = r_f[r_dst[1:0]];
        ld_mag   = ld_field[31] ? (33'h1_0000_0000 - {1'b0, ld_field}) : {1'b0, ld_field};

        // signed compare of the two operands
        eq = (r_opa_neg == r_opb_neg) && (r_opa_mag == r_opb_mag);
        if (r_opa_neg != r_opb_neg) begin
            lt = r_opa_neg;
        end else if (r_opa_neg) begin
            lt = r_opa_mag > r_opb_mag;
        end else begin
            lt = r_opa_mag < r_opb_mag;
        end
        case (r_mode)
            MODE_LT: cmp_t = lt;
            MODE_GT: cmp_t = !lt && !eq;
            MODE_EQ: cmp_t = eq;
            MODE_LE: cmp_t = lt || eq;
            MODE_GE: cmp_t = !lt;
            MODE_NE: cmp_t = !eq;
            default: cmp_t = 1'b0;
        endcase
        ovf = (r_opb_mag > LIM) || (r_opa_neg ? (r_opa_mag > LIM1) : (r_opa_mag > LIM));
        num = r_opa_neg ? (64'd0 - r_opa_mag) : r_opa_mag;

        if (r_pend) begin
            case (r_op)
                OP_LDI: begin
                    wr_en  = 1'b1;
                    wr_neg = ld_field[31];
                    wr_mag = 64'(ld_mag);
                end
                OP_MUL: begin
                    wr_en  = 1'b1;
                    wr_mag = prod;
                    wr_neg = (r_opa_neg ^ r_opb_neg) && (prod != '0);
                end
                OP_ADD, OP_SUB: begin
                    wr_en = 1'b1;
                    if (r_opa_neg == bneg) begin
                        wr_mag = r_opa_mag + r_opb_mag;
                        wr_neg = r_opa_neg;
                    end else if (r_opa_mag >= r_opb_mag) begin
                        wr_mag = r_opa_mag - r_opb_mag;
                        wr_neg = r_opa_neg;
                    end else begin
                        wr_mag = r_opb_mag - r_opa_mag;
                        wr_neg = bneg;
                    end
                    wr_neg = wr_neg && (wr_mag != '0);
                end
                OP_SGN: begin
                    wr_en  = 1'b1;
                    wr_mag = r_opa_mag;
                    wr_neg = (r_opa_neg ^ r_opb_neg) && (r_opa_mag != '0);
                end
                OP_GCD: begin
                    n_grun = 1'b1;
                    n_gx   = r_opa_mag;
                    n_gy   = r_opb_mag;
                    n_gk   = '0;
                end
                OP_DIVQ, OP_DIVU, OP_DIVR: begin
                    n_drun = 1'b1;
                    n_dq   = r_opa_mag;
                    n_dd   = r_opb_mag;
                    n_dr   = '0;
                    n_dcnt = '0;
                    n_drem = (r_op == OP_DIVR);
                    n_dneg = (r_op != OP_DIVU) && r_opa_neg;
                end
                OP_OUT: begin
                    out_en = 1'b1;
                    case (r_kind)
                        K_ST0:   n_out = '0;
                        K_ST1:   n_out = {ST_ZERO, 64'd0};
                        K_CMP:   n_out = {ST_OK, cmp_t, 63'd0};
                        default: begin
                            if (ovf) begin
                                n_out = {ST_OVF, 64'd0};
                            end else begin
                                n_out = {ST_OK, 1'b0, r_opb_mag[30:0], num[31:0]};
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end

        // binary gcd, one step per cycle
        if (r_grun) begin
            if (r_gx == '0 || r_gy == '0) begin
                gval    = (r_gx | r_gy) << r_gk;
                wr_en   = 1'b1;
                wr_addr = R_G;
                wr_neg  = 1'b0;
                wr_mag  = (gval == '0) ? 64'd1 : gval;
                n_grun  = 1'b0;
            end else if (!r_gx[0] && !r_gy[0]) begin
                n_gx = r_gx >> 1;
                n_gy = r_gy >> 1;
                n_gk = r_gk + 6'd1;
            end else if (!r_gx[0]) begin
                n_gx = r_gx >> 1;
            end else if (!r_gy[0]) begin
                n_gy = r_gy >> 1;
            end else if (r_gx >= r_gy) begin
                n_gx = r_gx - r_gy;
            end else begin
                n_gy = r_gy - r_gx;
            end
        end

        // restoring divider, one quotient bit per cycle
        if (r_drun) begin
            dtrial = {r_dr[MAG_W-1:0], r_dq[MAG_W-1]};
            if (dtrial >= {1'b0, r_dd}) begin
                dtrial = dtrial - {1'b0, r_dd};
                qbit   = 1'b1;
            end
            n_dr   = dtrial;
            n_dq   = {r_dq[MAG_W-2:0], qbit};
            n_dcnt = r_dcnt + 6'd1;
            if (r_dcnt == 6'(MAG_W - 1)) begin
                dres    = r_drem ? dtrial[MAG_W-1:0] : {r_dq[MAG_W-2:0], qbit};
                wr_en   = 1'b1;
                wr_addr = r_dst;
                wr_mag  = dres;
                wr_neg  = r_dneg && (dres != '0);
                n_drun  = 1'b0;
            end
        end
    end

    assign o_sts.busy     = r_pend || r_grun || r_drun;
    assign o_sts.mode     = r_mode;
    assign o_sts.bad_mode = r_mode > MODE_NE;
    assign o_sts.den_zero = (r_f[1] == '0) || (r_f[3] == '0);
    assign o_sts.bn_zero  = (r_f[2] == '0);
    assign o_result       = r_out;

endmodule

>>> rtl/rau_controller.sv
// ----------------------------------------------------------------------------
// rau_controller
// Micro-sequencer: walks the operation program for the current mode and
// drives the stream handshakes.
// ----------------------------------------------------------------------------
module rau_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output rau_pkg::t_cmd o_cmd,
    input  rau_pkg::t_sts i_sts
);
    import rau_pkg::*;

    localparam logic [4:0] PC_BODY = 5'd12;

    typedef struct packed {
        t_op  op;
        t_reg dst;
        t_reg s1;
        t_reg s2;
    } t_uop;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_EMIT, S_POST} t_state;

    t_state     r_state;
    logic [4:0] r_pc;
    t_kind      r_kind;
    logic       r_valid;
    t_uop       u;
    logic       div_zero;

    // reduce n/d: gcd, divide numerator, fix sign, divide denominator
    function automatic t_uop red(t_reg n, t_reg d, logic [4:0] j);
        t_uop r;
        case (j)
            5'd0:    r = '{OP_GCD, R_G, n, d};
            5'd1:    r = '{OP_DIVQ, n, n, R_G};
            5'd2:    r = '{OP_SGN, n, n, d};
            5'd3:    r = '{OP_DIVU, d, d, R_G};
            default: r = '{OP_END, R_AN, R_AN, R_AN};
        endcase
        return r;
    endfunction

    function automatic t_uop ucode(logic [MODE_W-1:0] mode, logic [4:0] pc);
        t_uop       r;
        logic [4:0] k;
        logic [4:0] len;
        r   = '{OP_END, R_AN, R_AN, R_AN};
        k   = pc - PC_BODY;
        len = 5'd2;
        if (pc < 5'd4) begin
            r = '{OP_LDI, t_reg'(pc[2:0]), R_AN, R_AN};
        end else if (pc < 5'd8) begin
            r = red(R_AN, R_AD, pc - 5'd4);
        end else if (pc < PC_BODY) begin
            r = red(R_BN, R_BD, pc - 5'd8);
        end else begin
            case (mode) inside
                MODE_ADD, MODE_SUB: begin
                    len = 5'd4;
                    case (k)
                        5'd0:    r = '{OP_MUL, R_RN, R_AN, R_BD};
                        5'd1:    r = '{OP_MUL, R_T, R_BN, R_AD};
                        5'd2:    r = '{(mode == MODE_SUB) ? OP_SUB : OP_ADD, R_RN, R_RN, R_T};
                        5'd3:    r = '{OP_MUL, R_RD, R_AD, R_BD};
                        default: r = red(R_RN, R_RD, k - len);
                    endcase
                end
                MODE_MUL: begin
                    case (k)
                        5'd0:    r = '{OP_MUL, R_RN, R_AN, R_BN};
                        5'd1:    r = '{OP_MUL, R_RD, R_AD, R_BD};
                        default: r = red(R_RN, R_RD, k - len);
                    endcase
                end
                MODE_DIV: begin
                    case (k)
                        5'd0:    r = '{OP_MUL, R_RN, R_AN, R_BD};
                        5'd1:    r = '{OP_MUL, R_RD, R_AD, R_BN};
                        default: r = red(R_RN, R_RD, k - len);
                    endcase
                end
                MODE_REM: begin
                    len = 5'd4;
                    case (k)
                        5'd0:    r = '{OP_MUL, R_RN, R_AN, R_BD};
                        5'd1:    r = '{OP_MUL, R_T, R_AD, R_BN};
                        5'd2:    r = '{OP_DIVR, R_RN, R_RN, R_T};
                        5'd3:    r = '{OP_MUL, R_RD, R_AD, R_BD};
                        default: r = red(R_RN, R_RD, k - len);
                    endcase
                end
                default: begin
                    case (k)
                        5'd0:    r = '{OP_MUL, R_T, R_AN, R_BD};
                        5'd1:    r = '{OP_MUL, R_RD, R_BN, R_AD};
                        default: r = '{OP_END, R_AN, R_AN, R_AN};
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    assign u        = ucode(i_sts.mode, r_pc);
    assign div_zero = (r_pc == PC_BODY) && i_sts.bn_zero &&
                      ((i_sts.mode == MODE_DIV) || (i_sts.mode == MODE_REM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_kind  <= K_ST0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_m_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_pc <= '0;
                    if (i_sts.bad_mode) begin
                        r_kind  <= K_ST0;
                        r_state <= S_EMIT;
                    end else if (i_sts.den_zero) begin
                        r_kind  <= K_ST1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (div_zero) begin
                        r_kind  <= K_ST1;
                        r_state <= S_EMIT;
                    end else if (u.op == OP_END) begin
                        r_kind  <= (i_sts.mode >= MODE_LT) ? K_CMP : K_ARITH;
                        r_state <= S_EMIT;
                    end else begin
                        r_pc    <= r_pc + 5'd1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!i_sts.busy) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_EMIT: begin
                    if (!r_valid || i_m_tready) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '{1'b0, OP_NOP, R_AN, R_AN, R_AN, K_ST0};
        unique case (r_state)
            S_IDLE: o_cmd.load_in = i_s_tvalid;
            S_ISSUE: begin
                if (!div_zero && u.op != OP_END) begin
                    o_cmd.op  = u.op;
                    o_cmd.dst = u.dst;
                    o_cmd.s1  = u.s1;
                    o_cmd.s2  = u.s2;
                end
            end
            S_EMIT: begin
                if (!r_valid || i_m_tready) begin
                    o_cmd.op   = OP_OUT;
                    o_cmd.s1   = (r_kind == K_CMP) ? R_T : R_RN;
                    o_cmd.s2   = R_RD;
                    o_cmd.kind = r_kind;
                end
            end
            default: ;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_valid;

endmodule

>>> rtl/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module rau_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [127:0] i_s_tdata,
    input logic [3:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [71:0]  o_m_tdata
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[65:64] != 2'd3)
        else $error("undefined status code");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] != 2'd0 |-> o_m_tdata[63:0] == 64'd0)
        else $error("nonzero fields on error result");

    // a zero denominator only comes with a zero numerator
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[65:64] == 2'd0 && o_m_tdata[62:32] == 31'd0
        |-> o_m_tdata[31:0] == 32'd0)
        else $error("numerator without denominator");

    // one operation in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
